// ===== src/triangle_unit_normal_defines.svh =====
// Assertion macros shared by the triangle unit normal checker.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

// Assert a property on the rising clock, skipped while reset is high.
`define TUN_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("triangle_unit_normal check failed");

// Assert a property on the rising clock, reset included.
`define TUN_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("triangle_unit_normal check failed");

`endif

// ===== src/tun_pkg.sv =====
// Shared constants and types of the triangle unit normal pipeline.
package tun_pkg;
  localparam int COORD_BITS_DEF       = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int OUT_BITS             = 16;
  localparam int NORM_BITS            = 31;
  localparam int SQ_BITS              = 2 * NORM_BITS;
  localparam int SUM_BITS             = 64;
  localparam int ROOT_BITS            = 32;

  // Sideband that travels with each face down the pipeline.
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } tun_side_t;
endpackage

// ===== src/tun_cross.sv =====
// Edge differences, partial products and cross product magnitudes (3 stages).
module tun_cross import tun_pkg::*; #(
  parameter int CB = COORD_BITS_DEF,
  parameter int MW = 2 * (CB + 1 - ((CB > 30) ? CB - 30 : 0))
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CB-1:0] pin [9],
  output logic [MW-1:0]        mag [3],
  output tun_side_t            side
);
  localparam int SH = (CB > 30) ? CB - 30 : 0;
  localparam int DW = CB + 1 - SH;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;

  logic signed [CB:0]   full [6];
  logic signed [CB:0]   shd  [6];
  logic signed [DW-1:0] d    [6];
  logic signed [PW-1:0] pr   [6];
  logic signed [CW-1:0] c    [3];
  logic                 v1, v2;

  // Form a = p1 - p2 and b = p1 - p3, floor-scaled for wide coordinates.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full[i]   = $signed({pin[i][CB-1], pin[i]}) - $signed({pin[i+3][CB-1], pin[i+3]});
      full[i+3] = $signed({pin[i][CB-1], pin[i]}) - $signed({pin[i+6][CB-1], pin[i+6]});
    end
    for (int i = 0; i < 6; i++) begin
      shd[i] = full[i] >>> SH;
    end
  end

  // Subtract partial products into the cross product components.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c[k] = $signed({pr[2*k][PW-1], pr[2*k]}) - $signed({pr[2*k+1][PW-1], pr[2*k+1]});
    end
  end

  // Advance valid bits and register the cross product signs.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      side <= '0;
    end else begin
      v1         <= in_valid;
      v2         <= v1;
      side.valid <= v2;
      side.degen <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        side.neg[k] <= c[k][CW-1];
      end
    end
  end

  // Hold payload of each stage.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      d[i] <= shd[i][DW-1:0];
    end
    pr[0] <= d[1] * d[5];
    pr[1] <= d[2] * d[4];
    pr[2] <= d[2] * d[3];
    pr[3] <= d[0] * d[5];
    pr[4] <= d[0] * d[4];
    pr[5] <= d[1] * d[3];
    for (int k = 0; k < 3; k++) begin
      mag[k] <= c[k][CW-1] ? MW'(-c[k]) : MW'(c[k]);
    end
  end
endmodule

// ===== src/tun_norm.sv =====
// Largest magnitude, leading one search, normalize shift and sum of squares (6 stages).
module tun_norm import tun_pkg::*; #(
  parameter int MW = 34
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [MW-1:0]        mag_in [3],
  input  tun_side_t            side_in,
  output logic [NORM_BITS-1:0] nm [3],
  output logic [SUM_BITS-1:0]  sum,
  output tun_side_t            side
);
  localparam int NG = (MW + 7) / 8;
  localparam int LW = $clog2(MW + 1);

  logic [MW-1:0]        mx;
  logic [MW-1:0]        mag1 [3], mag2 [3], mag3 [3];
  logic [MW-1:0]        mx1;
  logic [NG*8-1:0]      pad;
  logic [NG-1:0]        gnz, gnz2;
  logic [3:0]           glen [NG], glen2 [NG];
  logic [LW-1:0]        blen, blen3;
  logic [NORM_BITS-1:0] nmv [3], nm4 [3], nm5 [3];
  logic [MW-1:0]        shr [3];
  logic [SQ_BITS-1:0]   sq [3];
  tun_side_t            s1, s2, s3, s4, s5;

  // Pick the largest magnitude.
  always_comb begin
    mx = mag_in[0];
    if (mag_in[1] > mx) mx = mag_in[1];
    if (mag_in[2] > mx) mx = mag_in[2];
  end

  // Find the bit length inside each byte group.
  always_comb begin
    pad = (NG*8)'(mx1);
    for (int g = 0; g < NG; g++) begin
      gnz[g]  = |pad[g*8 +: 8];
      glen[g] = 4'd0;
      for (int b = 0; b < 8; b++) begin
        if (pad[g*8+b]) glen[g] = 4'(b + 1);
      end
    end
  end

  // Combine groups into the bit length of the largest magnitude.
  always_comb begin
    blen = '0;
    for (int g = 0; g < NG; g++) begin
      if (gnz2[g]) blen = LW'(g * 8 + int'(glen2[g]));
    end
  end

  // Shift every magnitude by the same amount into the normalized range.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      shr[k] = mag3[k] >> (int'(blen3) - NORM_BITS);
      if (int'(blen3) > NORM_BITS) begin
        nmv[k] = shr[k][NORM_BITS-1:0];
      end else begin
        nmv[k] = NORM_BITS'(mag3[k]) << (NORM_BITS - int'(blen3));
      end
    end
  end

  // Advance sideband, mark a zero cross product.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0; s2 <= '0; s3 <= '0; s4 <= '0; s5 <= '0; side <= '0;
    end else begin
      s1       <= {side_in.valid, (mx == '0), side_in.neg};
      s2       <= s1;
      s3       <= s2;
      s4       <= s3;
      s5       <= s4;
      side     <= s5;
    end
  end

  // Hold payload of each stage.
  always_ff @(posedge clk) begin
    mag1  <= mag_in;
    mx1   <= mx;
    mag2  <= mag1;
    gnz2  <= gnz;
    glen2 <= glen;
    mag3  <= mag2;
    blen3 <= blen;
    nm4   <= nmv;
    for (int k = 0; k < 3; k++) begin
      sq[k] <= nm4[k] * nm4[k];
    end
    nm5 <= nm4;
    sum <= SUM_BITS'(sq[0]) + SUM_BITS'(sq[1]) + SUM_BITS'(sq[2]);
    nm  <= nm5;
  end
endmodule

// ===== src/tun_sqrt.sv =====
// Pipelined integer square root, one root bit per stage (32 stages).
module tun_sqrt import tun_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SUM_BITS-1:0]  sum,
  input  logic [NORM_BITS-1:0] nm_in [3],
  input  tun_side_t            side_in,
  output logic [ROOT_BITS-1:0] len,
  output logic [NORM_BITS-1:0] nm [3],
  output tun_side_t            side
);
  localparam int RW = ROOT_BITS + 3;

  logic [RW-1:0]        rem_q  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q [ROOT_BITS];
  logic [SUM_BITS-1:0]  x_q    [ROOT_BITS];
  logic [NORM_BITS-1:0] nm_q   [ROOT_BITS][3];
  tun_side_t            side_q [ROOT_BITS];

  for (genvar st = 0; st < ROOT_BITS; st++) begin : g_step
    logic [RW-1:0]        rin, r2, trial;
    logic [ROOT_BITS-1:0] qin;
    logic [SUM_BITS-1:0]  xin;
    logic [NORM_BITS-1:0] nin [3];
    tun_side_t            sin;

    if (st == 0) begin : g_first
      assign rin = '0;
      assign qin = '0;
      assign xin = sum;
      assign nin = nm_in;
      assign sin = side_in;
    end else begin : g_next
      assign rin = rem_q[st-1];
      assign qin = root_q[st-1];
      assign xin = x_q[st-1];
      assign nin = nm_q[st-1];
      assign sin = side_q[st-1];
    end

    // Bring down two bits and try the next root bit.
    assign r2    = {rin[RW-3:0], xin[SUM_BITS-1 -: 2]};
    assign trial = RW'({qin, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[st] <= '0;
      end else begin
        side_q[st] <= sin;
      end
    end

    always_ff @(posedge clk) begin
      if (r2 >= trial) begin
        rem_q[st]  <= r2 - trial;
        root_q[st] <= {qin[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem_q[st]  <= r2;
        root_q[st] <= {qin[ROOT_BITS-2:0], 1'b0};
      end
      x_q[st]  <= {xin[SUM_BITS-3:0], 2'b00};
      nm_q[st] <= nin;
    end
  end

  assign len  = root_q[ROOT_BITS-1];
  assign nm   = nm_q[ROOT_BITS-1];
  assign side = side_q[ROOT_BITS-1];
endmodule

// ===== src/tun_div.sv =====
// Three-lane pipelined rounding divider, one quotient bit per stage.
module tun_div import tun_pkg::*; #(
  parameter int FB = NORMAL_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ROOT_BITS-1:0] len_in,
  input  logic [NORM_BITS-1:0] nm [3],
  input  tun_side_t            side_in,
  output logic [FB:0]          q [3],
  output tun_side_t            side
);
  localparam int QB = FB + 1;
  localparam int NW = NORM_BITS + QB;

  logic [NW-1:0]        num [3];
  logic [ROOT_BITS-1:0] rem_q  [QB+1][3];
  logic [QB-1:0]        word_q [QB+1][3];
  logic [ROOT_BITS-1:0] len_q  [QB+1];
  tun_side_t            side_q [QB+1];

  // Add half the divisor; the top bits start the remainder.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = {nm[k], {FB{1'b0}}} + NW'(len_in >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_q[0] <= '0;
    end else begin
      side_q[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    len_q[0] <= len_in;
    for (int k = 0; k < 3; k++) begin
      rem_q[0][k]  <= ROOT_BITS'(num[k][NW-1:QB]);
      word_q[0][k] <= num[k][QB-1:0];
    end
  end

  for (genvar st = 1; st <= QB; st++) begin : g_step
    logic [ROOT_BITS:0] r2 [3];
    logic [2:0]         ge;

    // Shift in one numerator bit and compare against the divisor.
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        r2[k] = {rem_q[st-1][k], word_q[st-1][k][QB-1]};
        ge[k] = r2[k] >= {1'b0, len_q[st-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[st] <= '0;
      end else begin
        side_q[st] <= side_q[st-1];
      end
    end

    always_ff @(posedge clk) begin
      len_q[st] <= len_q[st-1];
      for (int k = 0; k < 3; k++) begin
        rem_q[st][k]  <= ge[k] ? ROOT_BITS'(r2[k] - {1'b0, len_q[st-1]})
                               : ROOT_BITS'(r2[k]);
        word_q[st][k] <= {word_q[st-1][k][QB-2:0], ge[k]};
      end
    end
  end

  assign q    = word_q[QB];
  assign side = side_q[QB];
endmodule

// ===== src/triangle_unit_normal.sv =====
// Top level of the triangle unit normal pipeline.
// Streaming unit face normal: one face is taken on every cycle that start is
// high (busy is high only during reset), and its normal appears with a
// one-cycle done strobe; the receiver cannot stall. The pipeline is made of
// 3 cross product stages, 6 normalize stages, the 32-stage square root, one
// divider setup stage, the one-bit-per-stage divider of NORMAL_FRAC_BITS + 1
// stages and the output register. Outputs are signed Q1.14; a zero cross
// product gives a zero normal with degenerate set.
module triangle_unit_normal import tun_pkg::*; #(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p1_z,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  input  logic signed [COORD_BITS-1:0] p2_z,
  input  logic signed [COORD_BITS-1:0] p3_x,
  input  logic signed [COORD_BITS-1:0] p3_y,
  input  logic signed [COORD_BITS-1:0] p3_z,
  output logic                         done,
  output logic signed [OUT_BITS-1:0]   normal_x,
  output logic signed [OUT_BITS-1:0]   normal_y,
  output logic signed [OUT_BITS-1:0]   normal_z,
  output logic                         degenerate
);
  localparam int SH = (COORD_BITS > 30) ? COORD_BITS - 30 : 0;
  localparam int MW = 2 * (COORD_BITS + 1 - SH);
  localparam int QB = NORMAL_FRAC_BITS + 1;

  logic signed [COORD_BITS-1:0] pin [9];
  logic [MW-1:0]                mag [3];
  logic [NORM_BITS-1:0]         nm_a [3], nm_b [3];
  logic [SUM_BITS-1:0]          sum;
  logic [ROOT_BITS-1:0]         len;
  logic [QB-1:0]                q [3];
  logic [QB:0]                  qn [3];
  logic signed [OUT_BITS-1:0]   outv [3];
  tun_side_t                    side_c, side_n, side_s, side_d;

  assign busy = rst;
  assign pin  = '{p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z};

  tun_cross #(.CB(COORD_BITS), .MW(MW)) u_cross (
    .clk, .rst, .in_valid(start && !busy), .pin, .mag, .side(side_c)
  );

  tun_norm #(.MW(MW)) u_norm (
    .clk, .rst, .mag_in(mag), .side_in(side_c), .nm(nm_a), .sum, .side(side_n)
  );

  tun_sqrt u_sqrt (
    .clk, .rst, .sum, .nm_in(nm_a), .side_in(side_n), .len, .nm(nm_b), .side(side_s)
  );

  tun_div #(.FB(NORMAL_FRAC_BITS)) u_div (
    .clk, .rst, .len_in(len), .nm(nm_b), .side_in(side_s), .q, .side(side_d)
  );

  // Apply the sign, drop the normal of a degenerate face.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qn[k]   = side_d.neg[k] ? -{1'b0, q[k]} : {1'b0, q[k]};
      outv[k] = side_d.degen ? '0 : OUT_BITS'($signed(qn[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_d.valid;
    end
  end

  always_ff @(posedge clk) begin
    normal_x   <= outv[0];
    normal_y   <= outv[1];
    normal_z   <= outv[2];
    degenerate <= side_d.degen;
  end
endmodule

// ===== src/tun_check.sv =====
// Port-level checker for the triangle unit normal, bound to the top level.
`include "triangle_unit_normal_defines.svh"

module tun_check import tun_pkg::*; #(
  parameter int LATENCY = NORMAL_FRAC_BITS_DEF + 44
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic signed [OUT_BITS-1:0] normal_x,
  input logic signed [OUT_BITS-1:0] normal_y,
  input logic signed [OUT_BITS-1:0] normal_z,
  input logic                       degenerate
);
  // Every transfer in gives a result a fixed latency later.
  `TUN_ASSERT(a_result_follows, (start && !busy) |-> ##LATENCY done)
  // No result appears without a matching transfer in.
  `TUN_ASSERT(a_no_spurious, done |-> ($past(start, LATENCY) && !$past(busy, LATENCY)))
  // A degenerate face reports a zero normal.
  `TUN_ASSERT(a_degen_zero, (done && degenerate) |->
    (normal_x == 0 && normal_y == 0 && normal_z == 0))
  // Busy only ever reflects reset.
  `TUN_ASSERT_ALWAYS(a_busy_reset, busy == rst)
endmodule

bind triangle_unit_normal tun_check #(.LATENCY(NORMAL_FRAC_BITS + 44)) u_tun_check (.*);
